@@ sv/pdcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pdcs_pkg;

    // Fixed field widths of the transaction payloads
    localparam int IN_W    = 32;
    localparam int COUNT_W = 11;
    localparam int SUM_W   = 36;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT,
        ST_ADD_LO,
        ST_ADD_HI,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ sv/proper_divisor_count_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------------------
// input    | in        | s_valid / s_ready   | s_number[31:0]
// result   | out       | m_valid / m_ready   | m_divisor_count[10:0], m_divisor_sum[35:0],
//          |           |                     | m_is_perfect, m_invalid
//
// Sequencing: each trial divisor i takes one pass of the shared restoring divider,
// and each divisor found is then added to the totals in its own add state. Trials
// run for i = 1 .. floor(sqrt(n)) + 1; the last trial only finds that i is past the
// root. A number n below 2 goes straight from idle to the result, with no trial.
// Reset (aresetn, synchronous, active low) returns the sequencer to idle.
// s_ready is high only when idle; the result is held in registers until m_ready.
module proper_divisor_count_sum #(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [pdcs_pkg::IN_W-1:0]   s_number,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [pdcs_pkg::COUNT_W-1:0]     m_divisor_count,
    output logic [pdcs_pkg::SUM_W-1:0]       m_divisor_sum,
    output logic                             m_is_perfect,
    output logic                             m_invalid
);

    // Width for the saturating add: wide enough for sum plus any cofactor
    localparam int AW = ((NUM_WIDTH > pdcs_pkg::SUM_W) ? NUM_WIDTH : pdcs_pkg::SUM_W) + 1;

    pdcs_pkg::state_t state_reg, state_next;

    logic [NUM_WIDTH-1:0]         n_in;
    logic [NUM_WIDTH-1:0]         n_reg, n_next;
    logic [NUM_WIDTH-1:0]         i_reg, i_next;
    logic [pdcs_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [pdcs_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic                         over_reg, over_next;
    logic                         inval_reg, inval_next;

    logic                         div_start;
    logic                         div_done;
    logic [NUM_WIDTH-1:0]         div_quo;
    logic [NUM_WIDTH-1:0]         div_rem;

    logic                         s_hs;
    logic                         n_small;
    logic                         past_root;   // i > n / i, so i > floor(sqrt(n))
    logic                         is_div;
    logic                         need_cof;    // cofactor is distinct and not n itself
    logic [NUM_WIDTH-1:0]         addend;
    logic [AW-1:0]                sum_wide;
    logic                         sum_ovf;

    // Only the low NUM_WIDTH bits of the number take part
    generate
        if (NUM_WIDTH <= pdcs_pkg::IN_W) begin : g_trunc
            assign n_in = s_number[NUM_WIDTH-1:0];
        end else begin : g_ext
            assign n_in = {{(NUM_WIDTH - pdcs_pkg::IN_W){1'b0}}, s_number};
        end
    endgenerate

    assign s_hs      = s_valid && s_ready;
    assign n_small   = (n_in < NUM_WIDTH'(2));
    assign past_root = (i_reg > div_quo);
    assign is_div    = (div_rem == '0);
    assign need_cof  = (i_reg != NUM_WIDTH'(1)) && (div_quo != i_reg);

    // Shared saturating accumulator: adds i on the low pass, n / i on the high pass
    assign addend   = (state_reg == pdcs_pkg::ST_ADD_HI) ? div_quo : i_reg;
    assign sum_wide = AW'(sum_reg) + AW'(addend);
    assign sum_ovf  = (sum_wide > AW'(pdcs_pkg::SUM_MAX));

    pdcs_div #(
        .W (NUM_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (i_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pdcs_pkg::ST_IDLE: begin
                if (s_hs) begin
                    state_next = n_small ? pdcs_pkg::ST_DONE : pdcs_pkg::ST_DIV;
                end
            end
            pdcs_pkg::ST_DIV: begin
                state_next = pdcs_pkg::ST_WAIT;
            end
            pdcs_pkg::ST_WAIT: begin
                if (div_done) begin
                    if (past_root) begin
                        state_next = pdcs_pkg::ST_DONE;
                    end else if (is_div) begin
                        state_next = pdcs_pkg::ST_ADD_LO;
                    end else begin
                        state_next = pdcs_pkg::ST_DIV;
                    end
                end
            end
            pdcs_pkg::ST_ADD_LO: begin
                state_next = need_cof ? pdcs_pkg::ST_ADD_HI : pdcs_pkg::ST_DIV;
            end
            pdcs_pkg::ST_ADD_HI: begin
                state_next = pdcs_pkg::ST_DIV;
            end
            pdcs_pkg::ST_DONE: begin
                if (m_ready) begin
                    state_next = pdcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        div_start  = 1'b0;
        n_next     = n_reg;
        i_next     = i_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        over_next  = over_reg;
        inval_next = inval_reg;
        case (state_reg)
            pdcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_hs) begin
                    n_next     = n_in;
                    i_next     = NUM_WIDTH'(1);
                    count_next = '0;
                    sum_next   = '0;
                    over_next  = 1'b0;
                    inval_next = n_small;
                end
            end
            pdcs_pkg::ST_DIV: begin
                div_start = 1'b1;
            end
            pdcs_pkg::ST_WAIT: begin
                if (div_done && !past_root && !is_div) begin
                    i_next = i_reg + 1'b1;
                end
            end
            pdcs_pkg::ST_ADD_LO, pdcs_pkg::ST_ADD_HI: begin
                if (count_reg != pdcs_pkg::COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
                if (sum_ovf) begin
                    sum_next  = pdcs_pkg::SUM_MAX;
                    over_next = 1'b1;
                end else begin
                    sum_next = sum_wide[pdcs_pkg::SUM_W-1:0];
                end
                // Move to the next trial once this divisor's terms are in
                if (state_reg == pdcs_pkg::ST_ADD_HI || !need_cof) begin
                    i_next = i_reg + 1'b1;
                end
            end
            pdcs_pkg::ST_DONE: begin
                m_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg     <= n_next;
        i_reg     <= i_next;
        count_reg <= count_next;
        sum_reg   <= sum_next;
        over_reg  <= over_next;
        inval_reg <= inval_next;
    end

    // Result registers are stable for the whole of ST_DONE
    assign m_divisor_count = count_reg;
    assign m_divisor_sum   = sum_reg;
    assign m_invalid       = inval_reg;
    assign m_is_perfect    = !inval_reg && !over_reg && (AW'(sum_reg) == AW'(n_reg));

endmodule

`default_nettype wire

@@ sv/pdcs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
// Quotient and remainder hold after the done pulse until the next start.
module pdcs_div #(
    parameter int W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (diff[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end else begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ tb/divisor_sum_checker.sv @@
`timescale 1ns / 1ps

module divisor_sum_checker #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [pdcs_pkg::IN_W-1:0]             s_number,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [pdcs_pkg::COUNT_W-1:0]          m_divisor_count,
    input  logic [pdcs_pkg::SUM_W-1:0]            m_divisor_sum,
    input  logic                                  m_is_perfect,
    input  logic                                  m_invalid,
    output int                                    mismatch_total,
    output int                                    outstanding,
    output int                                    results_checked
);

    typedef struct {
        logic [pdcs_pkg::IN_W-1:0]    number;
        logic [pdcs_pkg::COUNT_W-1:0] count;
        logic [pdcs_pkg::SUM_W-1:0]   sum;
        logic                         perfect;
        logic                         invalid;
    } aliquot_t;

    aliquot_t awaited_results[$];
    aliquot_t want;
    int       bad_results;
    int       compared;

    // Add one divisor to the running tally, both totals saturating.
    function automatic void credit(inout logic [63:0] tally, inout logic [63:0] total,
                                   inout bit saturated, input logic [63:0] divisor);
        logic [63:0] ceiling;
        ceiling = 64'(pdcs_pkg::SUM_MAX);
        if (tally < 64'(pdcs_pkg::COUNT_MAX))
            tally++;
        if (divisor > ceiling - total) begin
            total     = ceiling;
            saturated = 1'b1;
        end else begin
            total += divisor;
        end
    endfunction

    function automatic aliquot_t analyse_number(input logic [pdcs_pkg::IN_W-1:0] raw);
        aliquot_t    res;
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] trial;
        logic [63:0] tally;
        logic [63:0] total;
        bit          saturated;
        res        = '{default: '0};
        res.number = raw;
        n          = 64'(raw);
        if (NUM_WIDTH < 64)
            n = n & ((64'd1 << NUM_WIDTH) - 64'd1);
        if (n < 64'd2) begin
            res.invalid = 1'b1;
            return res;
        end
        // exact floor square root, one bit at a time from the top
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= n)
                root = probe;
        end
        tally     = '0;
        total     = '0;
        saturated = 1'b0;
        for (trial = 64'd1; trial <= root; trial++) begin
            if (n % trial == 64'd0) begin
                credit(tally, total, saturated, trial);
                if (trial != 64'd1 && trial * trial != n)
                    credit(tally, total, saturated, n / trial);
            end
        end
        res.count   = tally[pdcs_pkg::COUNT_W-1:0];
        res.sum     = total[pdcs_pkg::SUM_W-1:0];
        res.perfect = !saturated && total == n;
        return res;
    endfunction

    initial begin
        bad_results     = 0;
        compared        = 0;
        mismatch_total  = 0;
        outstanding     = 0;
        results_checked = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                awaited_results.push_back(analyse_number(s_number));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: result transaction with no number outstanding", $time);
                end else begin
                    want = awaited_results.pop_front();
                    compared++;
                    if (m_divisor_count !== want.count || m_divisor_sum !== want.sum ||
                        m_is_perfect !== want.perfect || m_invalid !== want.invalid) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"%0t: n=%0d count %0d/%0d sum %0d/%0d perfect %0b/%0b",
                                      " invalid %0b/%0b (expected/got)"},
                                     $time, want.number, want.count, m_divisor_count,
                                     want.sum, m_divisor_sum, want.perfect, m_is_perfect,
                                     want.invalid, m_invalid);
                    end
                end
            end
            mismatch_total  <= bad_results;
            outstanding     <= awaited_results.size();
            results_checked <= compared;
        end
    end

endmodule

@@ tb/tb_proper_divisor_count_sum.sv @@
`timescale 1ns / 1ps

// Top of the bench: drives numbers into the block, pulls results out, and
// gives the verdict. Prediction and comparison live in divisor_sum_checker,
// which hands back its mismatch count and the number of results still owed.
module tb_proper_divisor_count_sum;

    localparam int NUM_WIDTH    = 32;
    // Long receiver hold-off: well beyond the time a small number takes, so the
    // block finishes one, parks its result and then refuses the next number.
    localparam int HOLD_CYCLES  = 1500;
    // After the last result: let a couple of divider passes go by.
    localparam int DRAIN_CYCLES = 2 * (NUM_WIDTH + 2) + 32;
    // Slowest correct run is dominated by 2^32-1 (about 65536 trials, each a full
    // divider pass) plus ~120 smaller numbers and the stalls; the limit is
    // several times over that.
    localparam int CYCLE_LIMIT  = 20_000_000;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic [pdcs_pkg::IN_W-1:0]        s_number;
    logic                             m_valid;
    logic                             m_ready;
    logic [pdcs_pkg::COUNT_W-1:0]     m_divisor_count;
    logic [pdcs_pkg::SUM_W-1:0]       m_divisor_sum;
    logic                             m_is_perfect;
    logic                             m_invalid;

    int mismatch_total;
    int outstanding;
    int results_checked;
    int numbers_sent;
    int cycle_count;

    // steady: both sides run without idle gaps
    // hold_req: asks the receiver for one long hold-off
    bit steady;
    bit hold_req;

    // Directed corners: below-2 error cases, smallest valid values, squares
    // (root counted once), perfect numbers, primes, a highly composite value
    // and the all-ones 32-bit input.
    logic [pdcs_pkg::IN_W-1:0] corner_numbers[] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12, 32'd16, 32'd28,
        32'd36, 32'd97, 32'd496, 32'd945, 32'd8128, 32'd65536, 32'd65537,
        32'd720720, 32'd33550336, 32'hFFFF_FFFF
    };

    proper_divisor_count_sum #(
        .NUM_WIDTH(NUM_WIDTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_number        (s_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_divisor_count (m_divisor_count),
        .m_divisor_sum   (m_divisor_sum),
        .m_is_perfect    (m_is_perfect),
        .m_invalid       (m_invalid)
    );

    divisor_sum_checker #(
        .NUM_WIDTH(NUM_WIDTH)
    ) sum_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_number        (s_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_divisor_count (m_divisor_count),
        .m_divisor_sum   (m_divisor_sum),
        .m_is_perfect    (m_is_perfect),
        .m_invalid       (m_invalid),
        .mismatch_total  (mismatch_total),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle cycles before the next transaction on either side.
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    // Mostly small numbers keep the trial-division run time sane; squares and
    // products of small factors give many divisors, a few go up to 2^20.
    function automatic logic [pdcs_pkg::IN_W-1:0] pick_number();
        int unsigned pick;
        int unsigned root;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return pdcs_pkg::IN_W'($urandom_range(0, 1));
        else if (pick < 50)
            return pdcs_pkg::IN_W'($urandom_range(2, 255));
        else if (pick < 75)
            return pdcs_pkg::IN_W'($urandom_range(256, 4095));
        else if (pick < 85) begin
            root = $urandom_range(2, 400);
            return pdcs_pkg::IN_W'(root * root);
        end else if (pick < 92)
            return pdcs_pkg::IN_W'($urandom_range(1, 60) * $urandom_range(1, 60) *
                                   $urandom_range(2, 60));
        else
            return pdcs_pkg::IN_W'($urandom_range(4096, 1 << 20));
    endfunction

    // Offer one number. Valid is only lowered when a gap is drawn, so
    // back-to-back transactions keep it high with fresh data.
    task automatic send_number(input logic [pdcs_pkg::IN_W-1:0] value);
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_number <= value;
        do @(posedge aclk); while (!s_ready);
        numbers_sent++;
    endtask

    // Sender stands down until every owed result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    task automatic send_random(input int amount);
        repeat (amount) send_number(pick_number());
    endtask

    // Receiver: random stall before each transaction, once a long hold-off.
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (hold_req) begin
                gap      += HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_proper_divisor_count_sum NOT OK");
        $finish;
    end

    initial begin
        s_valid      = 1'b0;
        s_number     = '0;
        aresetn      = 1'b0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        numbers_sent = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (corner_numbers[k])
            send_number(corner_numbers[k]);
        drain_results();

        send_random(35);

        // no idling on either side
        steady = 1'b1;
        send_random(30);

        // receiver parks for a long while; sender keeps offering quick numbers
        hold_req = 1'b1;
        repeat (12) send_number(pdcs_pkg::IN_W'($urandom_range(0, 63)));
        steady = 1'b0;
        drain_results();

        send_random(25);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d numbers: invalid, squares, perfect, primes, 2^32-1, random",
                 numbers_sent);
        $display("with idle gaps, back-to-back and a long receiver stall; %0d results compared",
                 results_checked);
        if (mismatch_total == 0)
            $display("tb_proper_divisor_count_sum OK");
        else
            $display("tb_proper_divisor_count_sum NOT OK");
        $finish;
    end

endmodule
